// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the debounce panel RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define BDMP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BDMP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/bdmp_pkg.sv -----
// ---------------------------------------------------------------------------
// bdmp_pkg
// Types and constants of the button debounce and mode panel.
// ---------------------------------------------------------------------------
package bdmp_pkg;

	localparam int PIN_W   = 3;
	localparam int KEY_W   = 3;
	localparam int MODE_W  = 2;
	localparam int CNT_W   = 4;
	localparam int SLOPE_W = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	typedef enum logic [KEY_W-1:0] {
		KEY_NONE    = 3'd0,
		KEY_PROGRAM = 3'd1,
		KEY_ENTER   = 3'd2,
		KEY_UP      = 3'd3,
		KEY_DOWN    = 3'd4
	} key_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE_COUNT = 2'd0,
		CFG_SLOPE_STEP     = 2'd1,
		CFG_SLOPE_MAX      = 2'd2,
		CFG_SLOPE_MIN      = 2'd3
	} cfg_idx_t;

	localparam logic [CNT_W-1:0]   DEBOUNCE_RESET   = 4'd3;
	localparam logic [SLOPE_W-1:0] SLOPE_STEP_RESET = 5'd1;
	localparam logic [SLOPE_W-1:0] SLOPE_MAX_RESET  = 5'd20;
	localparam logic [SLOPE_W-1:0] SLOPE_MIN_RESET  = 5'd1;
	localparam logic [SLOPE_W-1:0] SLOPE_RESET      = 5'd10;

	typedef struct packed {
		logic [CNT_W-1:0]   debounce_count;
		logic [SLOPE_W-1:0] slope_step;
		logic [SLOPE_W-1:0] slope_max;
		logic [SLOPE_W-1:0] slope_min;
	} cfg_t;

	typedef struct packed {
		logic [MODE_W-1:0]  panel_mode;
		logic               led_idle_on;
		logic               program_led_on;
		logic [SLOPE_W-1:0] slope_value;
		logic               save_request;
	} panel_res_t;

endpackage

// ----- hdl/bdmp_if.sv -----
// ---------------------------------------------------------------------------
// bdmp_in_if / bdmp_out_if
// Valid/ready channels carrying pin samples in and panel results out.
// ---------------------------------------------------------------------------
interface bdmp_in_if import bdmp_pkg::*;;
	logic             valid;
	logic             ready;
	logic [PIN_W-1:0] pin_levels;

	modport source (output valid, output pin_levels, input ready);
	modport sink (input valid, input pin_levels, output ready);
endinterface

interface bdmp_out_if import bdmp_pkg::*;;
	logic               valid;
	logic               ready;
	logic [KEY_W-1:0]   key_code;
	logic [MODE_W-1:0]  panel_mode;
	logic               led_idle_on;
	logic               program_led_on;
	logic [SLOPE_W-1:0] slope_value;
	logic               save_request;

	modport source (
		output valid, output key_code, output panel_mode, output led_idle_on,
		output program_led_on, output slope_value, output save_request,
		input ready
	);
	modport sink (
		input valid, input key_code, input panel_mode, input led_idle_on,
		input program_led_on, input slope_value, input save_request,
		output ready
	);
endinterface

// ----- hdl/bdmp_filter.sv -----
// ---------------------------------------------------------------------------
// bdmp_filter
// Decodes active-low pins into a key code and debounces it.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdmp_filter import bdmp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic [PIN_W-1:0] pin_levels,
	input  logic [CNT_W-1:0] debounce_count,
	output key_t             key
);

	key_t             code;
	key_t             last_q;
	key_t             last_n;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_n;
	logic             hit;

	always_comb begin
		unique case (~pin_levels)
			3'b001: code = KEY_ENTER;
			3'b010: code = KEY_UP;
			3'b100: code = KEY_DOWN;
			3'b111: code = KEY_PROGRAM;
			default: code = KEY_NONE;
		endcase
	end

	always_comb begin
		hit     = 1'b0;
		key     = KEY_NONE;
		last_n  = last_q;
		count_n = count_q;
		if (count_q != '0) begin
			hit = (code == last_q) && (count_q < debounce_count);
			if (hit) begin
				count_n = count_q + CNT_W'(1);
				if (count_n == debounce_count)
					key = code;
			end
		end else begin
			last_n  = code;
			count_n = CNT_W'(1);
		end
		if (code != last_n) begin
			last_n  = code;
			count_n = CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= KEY_NONE;
			count_q <= '0;
		end else if (step) begin
			last_q  <= last_n;
			count_q <= count_n;
		end
	end

	`BDMP_ASSERT(a_key_matches_held, step && key != KEY_NONE |-> code == last_q, "key from a changed code")
	`BDMP_ASSERT(a_key_at_threshold, step && key != KEY_NONE |=> count_q == $past(debounce_count), "count not at threshold after key")
	`BDMP_ASSERT_ALWAYS(a_idle_holds, !arst_n || $past(step) || $stable(count_q) || $fell(arst_n) || $rose(arst_n) || !$past(arst_n), "count moved without an item")

endmodule

// ----- hdl/bdmp_panel.sv -----
// ---------------------------------------------------------------------------
// bdmp_panel
// Idle / program / save panel with saturating slope adjust.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bdmp_panel import bdmp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  key_t       key,
	input  cfg_t       cfg,
	output panel_res_t res
);

	typedef enum logic [MODE_W-1:0] {
		MODE_IDLE    = 2'd0,
		MODE_PROGRAM = 2'd1,
		MODE_SAVE    = 2'd2
	} mode_t;

	mode_t              mode_q;
	mode_t              mode_n;
	logic [SLOPE_W-1:0] slope_q;
	logic [SLOPE_W-1:0] slope_n;
	logic [SLOPE_W:0]   sum;
	logic [SLOPE_W-1:0] up_v;
	logic [SLOPE_W-1:0] dn_v;
	logic               dn_neg;

	// saturating step in tenths; min wins over max
	always_comb begin
		sum  = {1'b0, slope_q} + {1'b0, cfg.slope_step};
		up_v = (sum > {1'b0, cfg.slope_max}) ? cfg.slope_max : sum[SLOPE_W-1:0];
		if (up_v < cfg.slope_min)
			up_v = cfg.slope_min;
		dn_neg = slope_q < cfg.slope_step;
		dn_v   = slope_q - cfg.slope_step;
		if (dn_neg || dn_v < cfg.slope_min)
			dn_v = cfg.slope_min;
	end

	always_comb begin
		mode_n             = mode_q;
		slope_n            = slope_q;
		res.led_idle_on    = 1'b0;
		res.program_led_on = 1'b0;
		res.save_request   = 1'b0;
		unique case (mode_q)
			MODE_IDLE: begin
				res.led_idle_on = 1'b1;
				if (key == KEY_PROGRAM)
					mode_n = MODE_PROGRAM;
			end
			MODE_PROGRAM: begin
				res.program_led_on = 1'b1;
				if (key == KEY_UP)
					slope_n = up_v;
				if (key == KEY_DOWN)
					slope_n = dn_v;
				if (key == KEY_ENTER)
					mode_n = MODE_SAVE;
			end
			MODE_SAVE: begin
				res.led_idle_on    = 1'b1;
				res.program_led_on = 1'b1;
				res.save_request   = 1'b1;
				mode_n             = MODE_IDLE;
			end
			default: begin
			end
		endcase
		res.panel_mode  = mode_n;
		res.slope_value = slope_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			slope_q <= SLOPE_RESET;
		end else if (step) begin
			mode_q  <= mode_n;
			slope_q <= slope_n;
		end
	end

	`BDMP_ASSERT(a_save_one_tick, step && mode_q == MODE_SAVE |=> mode_q == MODE_IDLE, "save state held past one item")
	`BDMP_ASSERT(a_slope_only_in_program, step && mode_q != MODE_PROGRAM |=> $stable(slope_q), "slope changed outside program mode")

endmodule

// ----- hdl/button_debounce_mode_panel_unit.sv -----
// ---------------------------------------------------------------------------
// button_debounce_mode_panel_unit
// Pin debounce, key decode and three-state slope setting panel.
// ---------------------------------------------------------------------------
// One item on in_ch is one sampling tick of the three active-low button pins.
// Every item yields exactly one result item on out_ch: the debounced key of
// that tick, the panel mode after it, both LEDs, the slope in tenths and the
// save request pulse.
// The sample is captured in an input register, the debounce and panel
// logic run on it and the result lands in the output register. One item
// per cycle is sustained while out_ch stays ready; panel and debounce state
// update once per item as it leaves the input register. When out_ch stalls
// the output register holds its item and the input register can still take
// one more, so in_ch drops ready only when both are full. Configuration
// writes on cfg_we/cfg_index/cfg_data take effect at the next edge; the user
// must make them while no item is in flight, the block does not enforce it.
// Reset clears both valid flags, sets the registers to debounce 3, step 1,
// max 20, min 1, the panel to idle with slope 10 and the debouncer to no key.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module button_debounce_mode_panel_unit import bdmp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	bdmp_in_if.sink               in_ch,
	bdmp_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t             cfg_q;
	logic             v_s1;
	logic [PIN_W-1:0] pins_s1;
	logic             v_s2;
	logic [KEY_W-1:0] key_s2;
	panel_res_t       res_s2;
	logic             adv;
	logic             in_acc;
	key_t             key;
	panel_res_t       res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_count <= DEBOUNCE_RESET;
			cfg_q.slope_step     <= SLOPE_STEP_RESET;
			cfg_q.slope_max      <= SLOPE_MAX_RESET;
			cfg_q.slope_min      <= SLOPE_MIN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DEBOUNCE_COUNT: cfg_q.debounce_count <= cfg_data[CNT_W-1:0];
				CFG_SLOPE_STEP:     cfg_q.slope_step     <= cfg_data;
				CFG_SLOPE_MAX:      cfg_q.slope_max      <= cfg_data;
				CFG_SLOPE_MIN:      cfg_q.slope_min      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv          = v_s1 && (!v_s2 || out_ch.ready);
	assign in_ch.ready  = !v_s1 || adv;
	assign in_acc       = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc)
			pins_s1 <= in_ch.pin_levels;
	end

	bdmp_filter u_filter (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (adv),
		.pin_levels     (pins_s1),
		.debounce_count (cfg_q.debounce_count),
		.key            (key)
	);

	bdmp_panel u_panel (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.key    (key),
		.cfg    (cfg_q),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_s2 <= key;
			res_s2 <= res;
		end
	end

	assign out_ch.valid          = v_s2;
	assign out_ch.key_code       = key_s2;
	assign out_ch.panel_mode     = res_s2.panel_mode;
	assign out_ch.led_idle_on    = res_s2.led_idle_on;
	assign out_ch.program_led_on = res_s2.program_led_on;
	assign out_ch.slope_value    = res_s2.slope_value;
	assign out_ch.save_request   = res_s2.save_request;

	`BDMP_ASSERT(a_accept_fills_s1, in_acc |=> v_s1, "accepted item not held in input stage")
	`BDMP_ASSERT(a_adv_fills_s2, adv |=> v_s2, "processed item lost before output")

endmodule
